[rtl/marng_pkg.sv]
`default_nettype none

package marng_pkg;

  // Request codes carried in the req_type field
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_RANGE_MIN     = 2'd0;
  localparam logic [1:0] CFG_RANGE_MAX     = 2'd1;
  localparam logic [1:0] CFG_FALLBACK_SEED = 2'd2;

  localparam logic [31:0] RANGE_MIN_RST     = 32'h8000_0000;
  localparam logic [31:0] RANGE_MAX_RST     = 32'h7fff_ffff;
  localparam logic [31:0] FALLBACK_SEED_RST = 32'h0000_0001;

  // Lag-8 multiply-with-carry pools: one carry entry and eight lags
  localparam int unsigned POOL_DEPTH = 9;
  localparam int unsigned NUM_LAGS   = 8;
  localparam int unsigned COEF_W     = 12;
  localparam int unsigned PROD_W     = COEF_W + 16;

  localparam logic [COEF_W-1:0] COEF_A [NUM_LAGS] = '{
    12'd1949, 12'd1861, 12'd1831, 12'd1777, 12'd1493, 12'd1217, 12'd1069, 12'd1021
  };
  localparam logic [COEF_W-1:0] COEF_B [NUM_LAGS] = '{
    12'd1117, 12'd2237, 12'd3343, 12'd351, 12'd1461, 12'd2577, 12'd3693, 12'd1085
  };

  // Seeding chain
  localparam logic [14:0] MWC_MUL    = 15'd30903;
  localparam int unsigned SEED_STEPS = 2 * POOL_DEPTH;
  localparam int unsigned SEED_CNT_W = $clog2(SEED_STEPS);
  localparam logic [15:0] CARRY_MASK = 16'h7fff;

  typedef struct packed {
    logic        req_type;
    logic [31:0] seed;
  } marng_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic        [31:0] raw_word;
  } marng_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_PROD,
    ST_SUM,
    ST_MUL,
    ST_FIN
  } marng_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_seed;
    logic seed_step;
    logic seed_last;
    logic prod;
    logic sum;
    logic mul;
    logic load_out;
  } marng_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic range_ok;
  } marng_status_t;

endpackage

`default_nettype wire

[rtl/marng_ctrl.sv]
`default_nettype none

module marng_ctrl
  import marng_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_req_type_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire marng_status_t status_i,
  output marng_cmd_t         cmd_o
);

  marng_state_e            state_q, state_d;
  logic [SEED_CNT_W-1:0]   cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    accept  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        accept = in_valid_i;
        if (in_valid_i) begin
          if (in_req_type_i == REQ_RESEED) begin
            cmd_o.load_seed = 1'b1;
            cnt_d           = '0;
            state_d         = ST_SEED;
          end else if (status_i.range_ok) begin
            state_d = ST_PROD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        cmd_o.seed_last = (cnt_q == SEED_CNT_W'(SEED_STEPS - 1));
        cnt_d           = cnt_q + 1'b1;
        if (cmd_o.seed_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        cmd_o.load_out = !out_valid_q || !out_stall_i;
        if (cmd_o.load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.load_out || (out_valid_q && out_stall_i);
  end

  assign in_stall_o  = !accept && (state_q != ST_IDLE || !in_valid_i) ? 1'b1 : 1'b0;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/marng_dp.sv]
`default_nettype none

module marng_dp
  import marng_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [31:0] seed_i,
  input  wire marng_cmd_t cmd_i,
  output marng_status_t   status_o,
  output marng_out_t      out_data_o
);

  logic [31:0] range_min_q, range_max_q, fallback_seed_q;

  logic [15:0] pool_a_q [POOL_DEPTH];
  logic [15:0] pool_b_q [POOL_DEPTH];

  logic [PROD_W-1:0] prod_a_q [NUM_LAGS];
  logic [PROD_W-1:0] prod_b_q [NUM_LAGS];

  logic [32:0] span_q;
  logic [31:0] raw_q;
  logic [63:0] mul_q;
  logic [31:0] num_q, num_d;
  logic [31:0] seed_sel;
  logic [31:0] sum_a, sum_b;
  logic [31:0] scaled;
  logic        range_eq;
  marng_out_t  out_q, out_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q     <= RANGE_MIN_RST;
      range_max_q     <= RANGE_MAX_RST;
      fallback_seed_q <= FALLBACK_SEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RANGE_MIN:     range_min_q     <= cfg_data_i;
        CFG_RANGE_MAX:     range_max_q     <= cfg_data_i;
        CFG_FALLBACK_SEED: fallback_seed_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign status_o.range_ok = $signed(range_min_q) < $signed(range_max_q);
  assign range_eq          = (range_min_q == range_max_q);

  // Seeding chain, one step per cycle
  assign seed_sel = (seed_i == 32'd0) ? fallback_seed_q : seed_i;
  assign num_d    = 32'(32'(MWC_MUL) * 32'(num_q[15:0])) + 32'(num_q[31:16]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      num_q <= {1'b0, seed_sel[30:0]};
    end else if (cmd_i.seed_step) begin
      num_q <= num_d;
    end
  end

  // Lag sums over the registered products
  always_comb begin
    sum_a = 32'(pool_a_q[0]);
    sum_b = 32'(pool_b_q[0]);
    for (int i = 0; i < NUM_LAGS; i++) begin
      sum_a = sum_a + 32'(prod_a_q[i]);
      sum_b = sum_b + 32'(prod_b_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      for (int i = 0; i < NUM_LAGS; i++) begin
        prod_a_q[i] <= PROD_W'(PROD_W'(COEF_A[i]) * PROD_W'(pool_a_q[i+1]));
        prod_b_q[i] <= PROD_W'(PROD_W'(COEF_B[i]) * PROD_W'(pool_b_q[i+1]));
      end
      span_q <= {1'b0, range_max_q - range_min_q} + 33'd1;
    end
    if (cmd_i.sum) begin
      raw_q <= {sum_a[15:0], sum_b[15:0]};
    end
    if (cmd_i.mul) begin
      mul_q <= 64'(raw_q) * 64'(span_q[31:0]);
    end
  end

  // Pools: shift through both as one chain while seeding, advance on a draw
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < POOL_DEPTH; i++) begin
        pool_a_q[i] <= '0;
        pool_b_q[i] <= '0;
      end
    end else if (cmd_i.seed_step) begin
      for (int i = 0; i < POOL_DEPTH - 1; i++) begin
        pool_a_q[i] <= pool_a_q[i+1];
        pool_b_q[i] <= pool_b_q[i+1];
      end
      pool_a_q[POOL_DEPTH-1] <= pool_b_q[0];
      pool_b_q[POOL_DEPTH-1] <= num_d[15:0];
      if (cmd_i.seed_last) begin
        pool_a_q[0] <= pool_a_q[1] & CARRY_MASK;
        pool_b_q[0] <= pool_b_q[1] & CARRY_MASK;
      end
    end else if (cmd_i.sum) begin
      for (int i = POOL_DEPTH - 1; i > 1; i--) begin
        pool_a_q[i] <= pool_a_q[i-1];
        pool_b_q[i] <= pool_b_q[i-1];
      end
      pool_a_q[1] <= sum_a[15:0];
      pool_a_q[0] <= sum_a[31:16];
      pool_b_q[1] <= sum_b[15:0];
      pool_b_q[0] <= sum_b[31:16];
    end
  end

  // Full span of 2^32 means the scaled offset is the raw word itself
  assign scaled = span_q[32] ? raw_q : mul_q[63:32];

  always_comb begin
    if (status_o.range_ok) begin
      out_d.value    = $signed(range_min_q + scaled);
      out_d.raw_word = raw_q;
    end else begin
      out_d.value    = range_eq ? $signed(range_min_q) : 32'sd0;
      out_d.raw_word = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

[rtl/mother_of_all_rng_ranged_core.sv]
// Ranged dual lag-8 multiply-with-carry random generator.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): each item is a draw
// request or a reseed request. A draw gives exactly one output item on
// out_valid_o / out_stall_i / out_data_o (value scaled into the range and
// the raw 32-bit word); a reseed gives none.
// Configuration (cfg_valid_i / cfg_ready_o): always ready, index 0 range_min,
// 1 range_max, 2 fallback_seed; other indexes are dropped. Write only while
// the block is idle.
// A draw with range_min < range_max passes through the product, lag sum,
// range multiply and final add steps before its item is registered in the
// output; a degenerate range goes straight to the final step. The next
// item is taken once the block is back in idle.
// A reseed runs the 16-bit seeding chain one step per cycle, 18 steps, and
// the block accepts again once the last step is done.
// Reset clears both pools to zero (draws give raw word 0 until a reseed) and
// loads the configuration reset values. When the receiver stalls, the
// output register holds its item; the block may still accept and work one
// more item and then holds it until the output register frees up.
`default_nettype none

module mother_of_all_rng_ranged_core
  import marng_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire marng_in_t   in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output marng_out_t       out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  marng_cmd_t    cmd;
  marng_status_t status;

  // Configuration is always taken
  assign cfg_ready_o = 1'b1;

  marng_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_req_type_i (in_data_i.req_type),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  marng_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .seed_i      (in_data_i.seed),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/marng_chk.sv]
`default_nettype none

module marng_chk
  import marng_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire marng_in_t   in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire marng_out_t  out_data_o
);

  logic in_acc;
  logic reseed_acc;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign reseed_acc = in_acc && (in_data_i.req_type == REQ_RESEED);

  // A stalled output item stays and keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item dropped or changed while stalled");

  // One item at a time: the block is busy right after any acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input accepted while an item is in flight");

  // Seeding chain still keeps the input stalled at its next-to-last step
  a_reseed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reseed_acc |=> ##16 in_stall_o)
    else $error("reseed ended early");

  // A reseed produces no new output item at the start of its seeding chain
  a_reseed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reseed_acc |=> ##1 !$rose(out_valid_o))
    else $error("output item appeared after a reseed");

endmodule

bind mother_of_all_rng_ranged_core marng_chk u_marng_chk (.*);

`default_nettype wire
